/* sv/smti_pkg.sv */
// Shared types and constants of the shape mask test image generator.
// Used by smti_cfg and shape_mask_test_image_top; depends on nothing.

package smti_pkg;

  // image size used by the range checks
  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 1024;

  // field widths
  localparam int PIX_W       = 10;
  localparam int COORD_W     = 16;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  // a semi-axis that passes its check is below half the larger image side
  localparam int MAX_SIDE = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int AXIS_W   = $clog2(MAX_SIDE) - 1;
  localparam int SQ_W     = 2 * AXIS_W;
  localparam int PROD_W   = 4 * AXIS_W;

  // triangle edge function widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int TP_W   = 2 * DIFF_W;
  localparam int DEN_W  = TP_W + 1;
  localparam int N3_W   = DEN_W + 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_VALUE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_VALUE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_A          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_B          = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_C          = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_D          = 3'd6;

  // shape kinds, shape_mode bits 2:0
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_CIRCLE   = 3'd1;
  localparam logic [2:0] KIND_RECT     = 3'd2;
  localparam logic [2:0] KIND_ELLIPSE  = 3'd3;
  localparam logic [2:0] KIND_RING     = 3'd4;
  localparam logic [2:0] KIND_TRIANGLE = 3'd5;

  // register reset values
  localparam logic [DATA_W-1:0] RST_FILL_VALUE = 32'd1;
  localparam logic [DATA_W-1:0] RST_POINT_A    = 32'd32768500;
  localparam logic [DATA_W-1:0] RST_POINT_B    = 32'd2;
  localparam logic [DATA_W-1:0] RST_POINT_C    = 32'd32768500;
  localparam logic [DATA_W-1:0] RST_POINT_D    = 32'd1310740;

  // configuration as the pixel pipeline sees it, raw and precomputed
  typedef struct packed {
    logic [2:0]        kind;
    logic              fixed_bg;
    logic [DATA_W-1:0] bg_value;
    logic [DATA_W-1:0] fill_value;
    logic [COORD_W-1:0] a_x;
    logic [COORD_W-1:0] a_y;
    logic [COORD_W-1:0] b_x;
    logic [COORD_W-1:0] b_y;
    logic [COORD_W-1:0] c_x;
    logic [COORD_W-1:0] c_y;
    logic [COORD_W-1:0] d_x;
    logic [COORD_W-1:0] d_y;
    logic              err;
    logic [SQ_W-1:0]   a2;
    logic [SQ_W-1:0]   b2;
    logic [SQ_W-1:0]   c2;
    logic [SQ_W-1:0]   d2;
    logic [PROD_W-1:0] ab2_o;
    logic [PROD_W-1:0] ab2_i;
    logic [DIFF_W-1:0] ey23;
    logic [DIFF_W-1:0] ex32;
    logic [DIFF_W-1:0] ey31;
    logic [DIFF_W-1:0] ex13;
    logic [DEN_W-1:0]  den;
  } cfg_t;

endpackage

/* sv/shape_mask_test_image_top.sv */
// Top level of the shape mask test image generator: stream ports and pixel pipeline.
// Depends on smti_pkg and smti_cfg.
//
//   channel   direction  word fields (low bit first)
//   s_axis    in         tdata: pixel_x[9:0], pixel_y[19:10], zero pad to 24 bits
//   m_axis    out        tdata: pixel_value[31:0]; tuser: inside_shape, config_error
//   cfg       in         cfg_write, cfg_index (0..6), cfg_data 32 bits
//
// One pixel per cycle sustained while m_axis_tready is high; five register stages from accept to output valid.
// The stage holding the two-level product (squared offset times squared semi-axis)
// and the final quadratic compare set the depth.
// Synchronous reset clears the valid bits only, not the pipeline data registers; no clearing pass.
// Each stage advances when the next one is empty or advancing, so a stall on the
// output backs up stage by stage and bubbles close up.

module shape_mask_test_image_top import smti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel_x, pixel_y, pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_value
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // inside_shape, config_error
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  cfg_t cfg;

  smti_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  function automatic logic [COORD_W-1:0] absdiff(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    return (u >= v) ? (u - v) : (v - u);
  endfunction

  // stage valid bits and advance enables
  logic       v0, v1, v2, v3, v4;
  logic [4:0] en;

  assign en[4] = !v4 || m_axis_tready;
  assign en[3] = !v3 || en[4];
  assign en[2] = !v2 || en[3];
  assign en[1] = !v1 || en[2];
  assign en[0] = !v0 || en[1];
  assign s_axis_tready = en[0] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en[0]) v0 <= s_axis_tvalid;
      if (en[1]) v1 <= v0;
      if (en[2]) v2 <= v1;
      if (en[3]) v3 <= v2;
      if (en[4]) v4 <= v3;
    end
  end

  // stage 0: input word
  logic [PIX_W-1:0] s0_x, s0_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_x <= s_axis_tdata[PIX_W-1:0];
      s0_y <= s_axis_tdata[2*PIX_W-1:PIX_W];
    end
  end

  // stage 1: offsets, bounding tests, background, triangle partial products
  logic [COORD_W-1:0]      xe, ye, dxo, dyo, dxi, dyi;
  logic [2*PIX_W-1:0]      xy;
  logic signed [DIFF_W-1:0] pxd, pyd;

  logic [DATA_W-1:0]       s1_bg;
  logic [AXIS_W-1:0]       s1_dxo, s1_dyo, s1_dxi, s1_dyi;
  logic                    s1_ok_c, s1_ok_o, s1_ok_i, s1_rect;
  logic signed [TP_W-1:0]  s1_t1, s1_t2, s1_t3, s1_t4;

  assign xe  = {{(COORD_W-PIX_W){1'b0}}, s0_x};
  assign ye  = {{(COORD_W-PIX_W){1'b0}}, s0_y};
  assign dxo = absdiff(xe, cfg.a_x);
  assign dyo = absdiff(ye, cfg.a_y);
  assign dxi = absdiff(xe, cfg.c_x);
  assign dyi = absdiff(ye, cfg.c_y);
  assign xy  = s0_x * s0_y;
  assign pxd = $signed({1'b0, xe}) - $signed({1'b0, cfg.c_x});
  assign pyd = $signed({1'b0, ye}) - $signed({1'b0, cfg.c_y});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_bg   <= cfg.fixed_bg ? cfg.bg_value : {{(DATA_W-2*PIX_W){1'b0}}, xy};
      // offsets beyond the semi-axis fail the flag; kept ones fit AXIS_W bits
      s1_dxo  <= dxo[AXIS_W-1:0];
      s1_dyo  <= dyo[AXIS_W-1:0];
      s1_dxi  <= dxi[AXIS_W-1:0];
      s1_dyi  <= dyi[AXIS_W-1:0];
      s1_ok_c <= (dxo <= cfg.b_x) && (dyo <= cfg.b_x);
      s1_ok_o <= (dxo <= cfg.b_x) && (dyo <= cfg.b_y);
      s1_ok_i <= (dxi <= cfg.d_x) && (dyi <= cfg.d_y);
      s1_rect <= (xe >= cfg.a_x) && (xe <= cfg.b_x) && (ye >= cfg.a_y) && (ye <= cfg.b_y);
      s1_t1   <= $signed(cfg.ey23) * pxd;
      s1_t2   <= $signed(cfg.ex32) * pyd;
      s1_t3   <= $signed(cfg.ey31) * pxd;
      s1_t4   <= $signed(cfg.ex13) * pyd;
    end
  end

  // stage 2: squared offsets, edge sums
  logic [DATA_W-1:0]       s2_bg;
  logic [SQ_W-1:0]         s2_sqxo, s2_sqyo, s2_sqxi, s2_sqyi;
  logic                    s2_ok_c, s2_ok_o, s2_ok_i, s2_rect;
  logic signed [DEN_W-1:0] s2_n1, s2_n2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_bg   <= s1_bg;
      s2_sqxo <= s1_dxo * s1_dxo;
      s2_sqyo <= s1_dyo * s1_dyo;
      s2_sqxi <= s1_dxi * s1_dxi;
      s2_sqyi <= s1_dyi * s1_dyi;
      s2_ok_c <= s1_ok_c;
      s2_ok_o <= s1_ok_o;
      s2_ok_i <= s1_ok_i;
      s2_rect <= s1_rect;
      s2_n1   <= DEN_W'(s1_t1) + DEN_W'(s1_t2);
      s2_n2   <= DEN_W'(s1_t3) + DEN_W'(s1_t4);
    end
  end

  // stage 3: weighted squares, circle test, triangle sign test
  logic [SQ_W:0]          circ_sum;
  logic signed [N3_W-1:0] n3;
  logic                   den_pos, den_neg, n1_pos, n2_pos, n3_pos, n1_neg, n2_neg, n3_neg;
  logic                   tri_in;

  logic [DATA_W-1:0]      s3_bg;
  logic [PROD_W-1:0]      s3_po1, s3_po2, s3_pi1, s3_pi2;
  logic                   s3_ok_o, s3_ok_i, s3_rect, s3_circ, s3_tri;

  assign circ_sum = {1'b0, s2_sqxo} + {1'b0, s2_sqyo};
  assign n3 = N3_W'($signed(cfg.den)) - N3_W'(s2_n1) - N3_W'(s2_n2);

  // den strictly positive / negative, n1..n3 nonnegative / nonpositive, from sign bit and zero test
  assign den_pos = !cfg.den[DEN_W-1] && (cfg.den != '0);
  assign den_neg = cfg.den[DEN_W-1];
  assign n1_pos  = !s2_n1[DEN_W-1];
  assign n2_pos  = !s2_n2[DEN_W-1];
  assign n3_pos  = !n3[N3_W-1];
  assign n1_neg  = s2_n1[DEN_W-1] || (s2_n1 == '0);
  assign n2_neg  = s2_n2[DEN_W-1] || (s2_n2 == '0);
  assign n3_neg  = n3[N3_W-1] || (n3 == '0);
  assign tri_in  = (den_pos && n1_pos && n2_pos && n3_pos) ||
                   (den_neg && n1_neg && n2_neg && n3_neg);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_bg   <= s2_bg;
      s3_po1  <= s2_sqxo * cfg.b2;
      s3_po2  <= s2_sqyo * cfg.a2;
      s3_pi1  <= s2_sqxi * cfg.d2;
      s3_pi2  <= s2_sqyi * cfg.c2;
      s3_ok_o <= s2_ok_o;
      s3_ok_i <= s2_ok_i;
      s3_rect <= s2_rect;
      s3_circ <= s2_ok_c && (circ_sum < {1'b0, cfg.a2});
      s3_tri  <= tri_in;
    end
  end

  // stage 4: ellipse compares, shape select, output word
  logic outer_in, inner_in, shape_in, in_shape;

  assign outer_in = s3_ok_o &&
                    (({1'b0, s3_po1} + {1'b0, s3_po2}) < {1'b0, cfg.ab2_o});
  assign inner_in = s3_ok_i &&
                    (({1'b0, s3_pi1} + {1'b0, s3_pi2}) < {1'b0, cfg.ab2_i});

  always_comb begin
    unique case (cfg.kind)
      KIND_CIRCLE:   shape_in = s3_circ;
      KIND_RECT:     shape_in = s3_rect;
      KIND_ELLIPSE:  shape_in = outer_in;
      KIND_RING:     shape_in = outer_in && !inner_in;
      KIND_TRIANGLE: shape_in = s3_tri;
      default:       shape_in = 1'b0;
    endcase
  end

  assign in_shape = shape_in && !cfg.err;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m_axis_tdata <= in_shape ? cfg.fill_value : s3_bg;
      m_axis_tuser <= {cfg.err, in_shape};
    end
  end

  assign m_axis_tvalid = v4;

endmodule

/* sv/smti_cfg.sv */
// Configuration registers and the terms derived from them, refreshed every cycle.
// Depends on smti_pkg.

module smti_cfg import smti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  output cfg_t                   cfg
);

  logic [MODE_W-1:0] shape_mode;
  logic [DATA_W-1:0] background_value;
  logic [DATA_W-1:0] fill_value;
  logic [DATA_W-1:0] point_a;
  logic [DATA_W-1:0] point_b;
  logic [DATA_W-1:0] point_c;
  logic [DATA_W-1:0] point_d;

  // first level of derived terms
  logic              err;
  logic [SQ_W-1:0]   a2, b2, c2, d2;
  logic [DIFF_W-1:0] ey23, ex32, ey31, ex13;
  logic signed [TP_W-1:0] dp1, dp2;
  // second level
  logic [PROD_W-1:0] ab2_o, ab2_i;
  logic [DEN_W-1:0]  den;

  logic [COORD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
  logic               err_next;
  logic [DIFF_W-1:0]  ey23_c, ex32_c, ey31_c, ex13_c, ey13_c;

  function automatic logic box_fits(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                    logic [COORD_W-1:0] sa, logic [COORD_W-1:0] sb);
    return (cx >= sa) && (cy >= sb) &&
           (({1'b0, cx} + {1'b0, sa}) < (COORD_W+1)'(IMAGE_WIDTH)) &&
           (({1'b0, cy} + {1'b0, sb}) < (COORD_W+1)'(IMAGE_HEIGHT));
  endfunction

  function automatic logic off_image(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    return ({1'b0, px} >= (COORD_W+1)'(IMAGE_WIDTH)) ||
           ({1'b0, py} >= (COORD_W+1)'(IMAGE_HEIGHT));
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode       <= '0;
      background_value <= '0;
      fill_value       <= RST_FILL_VALUE;
      point_a          <= RST_POINT_A;
      point_b          <= RST_POINT_B;
      point_c          <= RST_POINT_C;
      point_d          <= RST_POINT_D;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHAPE_MODE:       shape_mode       <= cfg_data[MODE_W-1:0];
        REG_BACKGROUND_VALUE: background_value <= cfg_data;
        REG_FILL_VALUE:       fill_value       <= cfg_data;
        REG_POINT_A:          point_a          <= cfg_data;
        REG_POINT_B:          point_b          <= cfg_data;
        REG_POINT_C:          point_c          <= cfg_data;
        REG_POINT_D:          point_d          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a_x = point_a[COORD_W-1:0];
  assign a_y = point_a[DATA_W-1:COORD_W];
  assign b_x = point_b[COORD_W-1:0];
  assign b_y = point_b[DATA_W-1:COORD_W];
  assign c_x = point_c[COORD_W-1:0];
  assign c_y = point_c[DATA_W-1:COORD_W];
  assign d_x = point_d[COORD_W-1:0];
  assign d_y = point_d[DATA_W-1:COORD_W];

  // range checks per kind
  always_comb begin
    unique case (shape_mode[2:0])
      KIND_NONE:     err_next = 1'b0;
      KIND_CIRCLE:   err_next = !box_fits(a_x, a_y, b_x, b_x);
      KIND_RECT:     err_next = off_image(b_x, b_y) || (b_x < a_x) || (b_y < a_y);
      KIND_ELLIPSE:  err_next = !box_fits(a_x, a_y, b_x, b_y);
      KIND_RING:     err_next = !box_fits(a_x, a_y, b_x, b_y) || !box_fits(c_x, c_y, d_x, d_y);
      KIND_TRIANGLE: err_next = (point_a == point_b) || (point_b == point_c) ||
                                (point_a == point_c) || off_image(a_x, a_y) ||
                                off_image(b_x, b_y) || off_image(c_x, c_y);
      default:       err_next = 1'b1;
    endcase
  end

  // triangle edge differences, two's complement
  assign ey23_c = {1'b0, b_y} - {1'b0, c_y};
  assign ex32_c = {1'b0, c_x} - {1'b0, b_x};
  assign ey31_c = {1'b0, c_y} - {1'b0, a_y};
  assign ex13_c = {1'b0, a_x} - {1'b0, c_x};
  assign ey13_c = {1'b0, a_y} - {1'b0, c_y};

  // derived terms, refreshed every cycle from the registers
  always_ff @(posedge clk) begin
    err  <= err_next;
    a2   <= b_x[AXIS_W-1:0] * b_x[AXIS_W-1:0];
    b2   <= b_y[AXIS_W-1:0] * b_y[AXIS_W-1:0];
    c2   <= d_x[AXIS_W-1:0] * d_x[AXIS_W-1:0];
    d2   <= d_y[AXIS_W-1:0] * d_y[AXIS_W-1:0];
    ey23 <= ey23_c;
    ex32 <= ex32_c;
    ey31 <= ey31_c;
    ex13 <= ex13_c;
    dp1  <= $signed(ey23_c) * $signed(ex13_c);
    dp2  <= $signed(ex32_c) * $signed(ey13_c);
    ab2_o <= a2 * b2;
    ab2_i <= c2 * d2;
    den   <= DEN_W'(dp1) + DEN_W'(dp2);
  end

  always_comb begin
    cfg.kind       = shape_mode[2:0];
    cfg.fixed_bg   = shape_mode[3];
    cfg.bg_value   = background_value;
    cfg.fill_value = fill_value;
    cfg.a_x        = a_x;
    cfg.a_y        = a_y;
    cfg.b_x        = b_x;
    cfg.b_y        = b_y;
    cfg.c_x        = c_x;
    cfg.c_y        = c_y;
    cfg.d_x        = d_x;
    cfg.d_y        = d_y;
    cfg.err        = err;
    cfg.a2         = a2;
    cfg.b2         = b2;
    cfg.c2         = c2;
    cfg.d2         = d2;
    cfg.ab2_o      = ab2_o;
    cfg.ab2_i      = ab2_i;
    cfg.ey23       = ey23;
    cfg.ex32       = ex32;
    cfg.ey31       = ey31;
    cfg.ex13       = ex13;
    cfg.den        = den;
  end

endmodule

/* sv/smti_checker.sv */
// Port-level checks for the shape mask test image generator, bound to the top level.
// Depends on smti_pkg and shape_mask_test_image_top.

module smti_checker import smti_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // a shape that fails its checks is never applied
  a_err_not_inside: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("pixel marked inside a shape with a config error");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // an empty output stage always lets a new word in
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with the output stage empty");

endmodule

bind shape_mask_test_image_top smti_checker u_smti_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/tb_shape_mask_test_image_top.sv */
// Self-checking bench for shape_mask_test_image_top: streams pixel coordinates in,
// predicts each output word from its own copy of the shape registers and checks it.
// Depends on smti_pkg and the RTL top only.

module tb_shape_mask_test_image_top import smti_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PIX_MAX     = 1023;
  localparam int FIXED_BG    = 3;       // shape_mode bit selecting the fixed background

  // one predicted output word, tagged with its pixel for messages
  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [DATA_W-1:0] value;
    logic              in_shape;
    logic              err;
  } pixel_expect_t;

  // Shape register copy, pixel predictor and queue of words still owed
  class pixel_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] bg_value, fill_value, pa, pb, pc, pd;
    pixel_expect_t     owed_q[$];
    int                errors;

    function new();
      mode       = '0;
      bg_value   = '0;
      fill_value = RST_FILL_VALUE;
      pa         = RST_POINT_A;
      pb         = RST_POINT_B;
      pc         = RST_POINT_C;
      pd         = RST_POINT_D;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_SHAPE_MODE:       mode = data[MODE_W-1:0];
        REG_BACKGROUND_VALUE: bg_value = data;
        REG_FILL_VALUE:       fill_value = data;
        REG_POINT_A:          pa = data;
        REG_POINT_B:          pb = data;
        REG_POINT_C:          pc = data;
        REG_POINT_D:          pd = data;
        default: ;
      endcase
    endfunction

    function bit box_fits(longint cx, longint cy, longint a, longint b);
      return cx >= a && cy >= b && cx + a < IMAGE_WIDTH && cy + b < IMAGE_HEIGHT;
    endfunction

    // strict interior, exact quadratic compare
    function bit in_ellipse(longint cx, longint cy, longint a, longint b, longint x, longint y);
      longint ox, oy;
      ox = (x > cx) ? x - cx : cx - x;
      oy = (y > cy) ? y - cy : cy - y;
      if (a == 0 || b == 0 || ox > a || oy > b) return 1'b0;
      return ox * ox * b * b + oy * oy * a * a < a * a * b * b;
    endfunction

    function bit in_circle(longint cx, longint cy, longint r, longint x, longint y);
      longint ox, oy;
      ox = (x > cx) ? x - cx : cx - x;
      oy = (y > cy) ? y - cy : cy - y;
      if (ox > r || oy > r) return 1'b0;
      return ox * ox + oy * oy < r * r;
    endfunction

    // edge functions; edges count as inside, degenerate triangle is empty
    function bit in_triangle(longint x, longint y);
      longint x1, y1, x2, y2, x3, y3, den, n1, n2, n3;
      x1 = pa[15:0]; y1 = pa[31:16];
      x2 = pb[15:0]; y2 = pb[31:16];
      x3 = pc[15:0]; y3 = pc[31:16];
      den = (y2 - y3) * (x1 - x3) + (x3 - x2) * (y1 - y3);
      n1  = (y2 - y3) * (x - x3) + (x3 - x2) * (y - y3);
      n2  = (y3 - y1) * (x - x3) + (x1 - x3) * (y - y3);
      n3  = den - n1 - n2;
      if (den > 0) return n1 >= 0 && n2 >= 0 && n3 >= 0;
      if (den < 0) return n1 <= 0 && n2 <= 0 && n3 <= 0;
      return 1'b0;
    endfunction

    function pixel_expect_t predict_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      pixel_expect_t r;
      longint x, y, ax, ay, bx, by, cx, cy, dx, dy;
      logic [DATA_W-1:0] bg;
      bit err, hit;
      x  = px;          y  = py;
      ax = pa[15:0];    ay = pa[31:16];
      bx = pb[15:0];    by = pb[31:16];
      cx = pc[15:0];    cy = pc[31:16];
      dx = pd[15:0];    dy = pd[31:16];
      bg  = mode[FIXED_BG] ? bg_value : DATA_W'(x * y);
      err = 1'b0;
      hit = 1'b0;
      case (mode[2:0])
        KIND_NONE: ;
        KIND_CIRCLE: begin
          err = !box_fits(ax, ay, bx, bx);
          if (!err) hit = in_circle(ax, ay, bx, x, y);
        end
        KIND_RECT: begin
          err = bx >= IMAGE_WIDTH || by >= IMAGE_HEIGHT || bx < ax || by < ay;
          if (!err) hit = x >= ax && x <= bx && y >= ay && y <= by;
        end
        KIND_ELLIPSE: begin
          err = !box_fits(ax, ay, bx, by);
          if (!err) hit = in_ellipse(ax, ay, bx, by, x, y);
        end
        KIND_RING: begin
          err = !box_fits(ax, ay, bx, by) || !box_fits(cx, cy, dx, dy);
          if (!err) hit = in_ellipse(ax, ay, bx, by, x, y) && !in_ellipse(cx, cy, dx, dy, x, y);
        end
        KIND_TRIANGLE: begin
          err = pa == pb || pb == pc || pa == pc ||
                ax >= IMAGE_WIDTH || bx >= IMAGE_WIDTH || cx >= IMAGE_WIDTH ||
                ay >= IMAGE_HEIGHT || by >= IMAGE_HEIGHT || cy >= IMAGE_HEIGHT;
          if (!err) hit = in_triangle(x, y);
        end
        default: err = 1'b1;
      endcase
      r.x        = px;
      r.y        = py;
      r.value    = hit ? fill_value : bg;
      r.in_shape = hit;
      r.err      = err;
      return r;
    endfunction

    // input word accepted: queue its expected output
    function void note_pixel(logic [IN_TDATA_W-1:0] word);
      owed_q.push_back(predict_pixel(word[PIX_W-1:0], word[2*PIX_W-1:PIX_W]));
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 200) $display("%0t: %s", $time, msg);
    endfunction

    // output word accepted: compare with the oldest expectation
    function void check_word(logic [DATA_W-1:0] value, logic [OUT_TUSER_W-1:0] flags);
      pixel_expect_t want;
      if (owed_q.size() == 0) begin
        flag_error($sformatf("word %h flags %b arrived with nothing expected", value, flags));
        return;
      end
      want = owed_q.pop_front();
      if (value !== want.value)
        flag_error($sformatf("pixel (%0d,%0d) pixel_value expected %h actual %h",
                             want.x, want.y, want.value, value));
      if (flags[0] !== want.in_shape)
        flag_error($sformatf("pixel (%0d,%0d) inside_shape expected %b actual %b",
                             want.x, want.y, want.in_shape, flags[0]));
      if (flags[1] !== want.err)
        flag_error($sformatf("pixel (%0d,%0d) config_error expected %b actual %b",
                             want.x, want.y, want.err, flags[1]));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;    // pixel_x, pixel_y, pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;    // pixel_value
  logic [OUT_TUSER_W-1:0] m_axis_tuser;    // inside_shape, config_error
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  pixel_scoreboard sb = new();
  int send_gap_pct;
  int recv_idle_pct;
  int hold_asks = 0;
  int cycle_count = 0;
  int fx_lo, fx_hi, fy_lo, fy_hi;           // region most random pixels fall in

  shape_mask_test_image_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shape_mask_test_image_top: mismatch");
      $finish;
    end
  end

  // word monitors on both channels
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin : sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic int clip(int v);
    return (v < 0) ? 0 : ((v > PIX_MAX) ? PIX_MAX : v);
  endfunction

  function automatic logic [DATA_W-1:0] pt(int x, int y);
    return {y[15:0], x[15:0]};
  endfunction

  // mostly small semi-axes, now and then up to the largest legal one
  function automatic int axis_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 80);
  endfunction

  function automatic void set_focus(int xl, int xh, int yl, int yh);
    fx_lo = clip(xl);
    fx_hi = clip(xh);
    fy_lo = clip(yl);
    fy_hi = clip(yh);
  endfunction

  // offer one pixel word, with random gaps before it; returns at a falling edge
  task automatic send_pixel(input int x, input int y);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, PIX_W'(y), PIX_W'(x)};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // stop sending and wait for every owed word plus pipeline slack
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_shape(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] bg,
                           input logic [DATA_W-1:0] fill, input logic [DATA_W-1:0] pa,
                           input logic [DATA_W-1:0] pb, input logic [DATA_W-1:0] pc,
                           input logic [DATA_W-1:0] pd);
    drain();
    write_reg(REG_SHAPE_MODE, DATA_W'(mode));
    write_reg(REG_BACKGROUND_VALUE, bg);
    write_reg(REG_FILL_VALUE, fill);
    write_reg(REG_POINT_A, pa);
    write_reg(REG_POINT_B, pb);
    write_reg(REG_POINT_C, pc);
    write_reg(REG_POINT_D, pd);
  endtask

  // random shape; one in five keeps fully random points (mostly range errors)
  task automatic random_shape();
    int kind, r, a, b, cx, cy, ia, ib, icx, icy, lo, hi;
    int x1, y1, x2, y2, x3, y3, sx, sy;
    logic [DATA_W-1:0] pa, pb, pc, pd;
    pa = $urandom;
    pb = $urandom;
    pc = $urandom;
    pd = $urandom;
    kind = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(0, 7);
    set_focus(0, PIX_MAX, 0, PIX_MAX);
    if ($urandom_range(0, 4) != 0) begin
      case (3'(kind))
        KIND_CIRCLE: begin
          r  = axis_len();
          cx = $urandom_range(r, PIX_MAX - r);
          cy = $urandom_range(r, PIX_MAX - r);
          pa = pt(cx, cy);
          pb = {pb[31:16], 16'(r)};
          set_focus(cx - r - 2, cx + r + 2, cy - r - 2, cy + r + 2);
        end
        KIND_RECT: begin
          x1 = $urandom_range(0, PIX_MAX);
          y1 = $urandom_range(0, PIX_MAX);
          x2 = $urandom_range(x1, clip(x1 + 150));
          y2 = $urandom_range(y1, clip(y1 + 150));
          pa = pt(x1, y1);
          pb = pt(x2, y2);
          set_focus(x1 - 2, x2 + 2, y1 - 2, y2 + 2);
        end
        KIND_ELLIPSE: begin
          a  = axis_len();
          b  = axis_len();
          cx = $urandom_range(a, PIX_MAX - a);
          cy = $urandom_range(b, PIX_MAX - b);
          pa = pt(cx, cy);
          pb = pt(a, b);
          set_focus(cx - a - 2, cx + a + 2, cy - b - 2, cy + b + 2);
        end
        KIND_RING: begin
          a  = $urandom_range(2, 120);
          b  = $urandom_range(2, 120);
          cx = $urandom_range(a, PIX_MAX - a);
          cy = $urandom_range(b, PIX_MAX - b);
          ia = $urandom_range(0, a);
          ib = $urandom_range(0, b);
          // inner center near the outer one, inner ellipse still in range
          lo  = (cx - 10 > ia) ? cx - 10 : ia;
          hi  = (cx + 10 < PIX_MAX - ia) ? cx + 10 : PIX_MAX - ia;
          icx = $urandom_range(lo, hi);
          lo  = (cy - 10 > ib) ? cy - 10 : ib;
          hi  = (cy + 10 < PIX_MAX - ib) ? cy + 10 : PIX_MAX - ib;
          icy = $urandom_range(lo, hi);
          pa = pt(cx, cy);
          pb = pt(a, b);
          pc = pt(icx, icy);
          pd = pt(ia, ib);
          set_focus(cx - a - 2, cx + a + 2, cy - b - 2, cy + b + 2);
        end
        KIND_TRIANGLE: begin
          x1 = $urandom_range(0, 900);
          y1 = $urandom_range(0, 900);
          if ($urandom_range(0, 7) == 0) begin
            // collinear vertices
            sx = $urandom_range(0, 60);
            sy = $urandom_range(0, 60);
            x2 = x1 + sx;      y2 = y1 + sy;
            x3 = x1 + 2 * sx;  y3 = y1 + 2 * sy;
          end else begin
            x2 = clip(x1 + int'($urandom_range(0, 240)) - 120);
            y2 = clip(y1 + int'($urandom_range(0, 240)) - 120);
            x3 = clip(x1 + int'($urandom_range(0, 240)) - 120);
            y3 = clip(y1 + int'($urandom_range(0, 240)) - 120);
          end
          pa = pt(x1, y1);
          pb = pt(x2, y2);
          pc = pt(x3, y3);
          set_focus(x1 - 122, x1 + 122, y1 - 122, y1 + 122);
        end
        default: ;
      endcase
    end
    set_shape({1'($urandom_range(0, 1)), 3'(kind)}, $urandom, $urandom, pa, pb, pc, pd);
  endtask

  task automatic send_random_pixel();
    if ($urandom_range(0, 99) < 65)
      send_pixel($urandom_range(fx_lo, fx_hi), $urandom_range(fy_lo, fy_hi));
    else
      send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
  endtask

  // stimulus
  initial begin : stimulus
    int phase;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_gap_pct  = 14;
    recv_idle_pct = 85;
    set_focus(0, PIX_MAX, 0, PIX_MAX);
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // reset settings: no shape, x*y background
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(PIX_MAX, 0);

    // circle: strict interior, points on and just off the edge
    set_shape({1'b1, KIND_CIRCLE}, '0, '1, pt(500, 500), pt(20, 0), pt(0, 0), pt(0, 0));
    send_pixel(500, 500);
    send_pixel(520, 500);
    send_pixel(519, 500);
    send_pixel(514, 514);
    send_pixel(515, 515);
    // zero radius is empty
    set_shape({1'b0, KIND_CIRCLE}, '0, '1, pt(500, 500), pt(0, 7), pt(0, 0), pt(0, 0));
    send_pixel(500, 500);
    // circle crossing the image border
    set_shape({1'b0, KIND_CIRCLE}, '0, '1, pt(10, 10), pt(20, 0), pt(0, 0), pt(0, 0));
    send_pixel(10, 10);

    // rectangle covering the whole image, then one past the right border
    set_shape({1'b1, KIND_RECT}, '1, '0, pt(0, 0), pt(PIX_MAX, PIX_MAX), pt(0, 0), pt(0, 0));
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    set_shape({1'b0, KIND_RECT}, '1, '0, pt(5, 5), pt(1024, 8), pt(0, 0), pt(0, 0));
    send_pixel(5, 5);

    // ellipse, then a zero semi-axis
    set_shape({1'b0, KIND_ELLIPSE}, '0, 32'h1234_5678, pt(512, 300), pt(100, 40),
              pt(0, 0), pt(0, 0));
    send_pixel(512, 300);
    send_pixel(612, 300);
    send_pixel(611, 300);
    set_shape({1'b0, KIND_ELLIPSE}, '0, 32'h1234_5678, pt(512, 300), pt(100, 0),
              pt(0, 0), pt(0, 0));
    send_pixel(512, 300);

    // ring: hole in the middle, then an empty inner ellipse
    set_shape({1'b1, KIND_RING}, 32'h5A5A_5A5A, 32'hA5A5_A5A5, pt(500, 500), pt(100, 100),
              pt(500, 500), pt(20, 20));
    send_pixel(500, 500);
    send_pixel(550, 500);
    set_shape({1'b1, KIND_RING}, 32'h5A5A_5A5A, 32'hA5A5_A5A5, pt(500, 500), pt(100, 100),
              pt(500, 500), pt(0, 20));
    send_pixel(500, 500);

    // triangle with vertex and hypotenuse hits
    set_shape({1'b0, KIND_TRIANGLE}, '0, 32'h0F0F_0F0F, pt(0, 0), pt(PIX_MAX, 0),
              pt(0, PIX_MAX), pt(0, 0));
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(511, 512);
    // collinear vertices: empty without error
    set_shape({1'b0, KIND_TRIANGLE}, '0, 32'h0F0F_0F0F, pt(0, 0), pt(1, 1), pt(2, 2), pt(0, 0));
    send_pixel(1, 1);
    // two equal vertices: error
    set_shape({1'b0, KIND_TRIANGLE}, '0, 32'h0F0F_0F0F, pt(3, 3), pt(3, 3), pt(9, 1), pt(0, 0));
    send_pixel(3, 3);

    // undefined kinds
    set_shape(4'h6, 32'hDEAD_BEEF, '1, pt(0, 0), pt(0, 0), pt(0, 0), pt(0, 0));
    send_pixel(7, 7);
    set_shape(4'hF, 32'hDEAD_BEEF, '1, pt(0, 0), pt(0, 0), pt(0, 0), pt(0, 0));
    send_pixel(7, 7);

    // random shapes under three flow-control regimes
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_gap_pct  = 85;
        recv_idle_pct = 14;
      end
      if (phase == 8) begin
        send_gap_pct  = 0;
        recv_idle_pct = 0;
      end
      random_shape();
      // long output stall while words keep coming: pipeline fills, input stalls
      if (phase == 9) hold_asks++;
      repeat (29) send_random_pixel();
      // sender pause until the block is empty
      if (phase == 2 || phase == 10) drain();
      repeat (29) send_random_pixel();
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0)
      $display("shape_mask_test_image_top: match");
    else
      $display("shape_mask_test_image_top: mismatch");
    $finish;
  end

endmodule
